FILE: hdl/alsm_pkg.sv
package alsm_pkg;

    // Pattern and window sizing
    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;
    localparam int WINDOW_DEPTH  = MAX_PATTERN;

    // Position counter stops at the smaller of 2^POSITION_BITS-1 and 2^32-1
    localparam int COUNT_W  = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam int OFFSET_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

    // Effective length and pattern byte index widths
    localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
    localparam int PAT_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LEN_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_END   = 3'd4;

    // Window of recent bytes, newest at index 0, and the pattern bytes
    typedef logic [WINDOW_DEPTH-1:0][7:0] t_window;
    typedef logic [MAX_PATTERN-1:0][7:0]  t_pattern;

    // Request payloads
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        logic                matched;
        logic [OFFSET_W-1:0] match_start;
        logic [OFFSET_W-1:0] match_end;
        logic                length_overflow;
    } t_out_item;

    // Tracker control and status
    typedef struct packed {
        logic shift;
        logic clear;
    } t_trk_ctrl;

    typedef struct packed {
        logic               seen;
        logic [COUNT_W-1:0] offset;
        logic [COUNT_W-1:0] count;
        logic               saturated;
        logic               tail_hit;
    } t_trk_status;

endpackage

FILE: hdl/anchored_literal_substring_match_core.sv
// Channel  Direction  Handshake                 Payload
// -------  ---------  ------------------------  -------------------------------
// in       input      i_in_valid / o_in_ready   i_in_data  (text_byte, is_end)
// out      output     o_out_valid / i_out_ready o_out_data (matched, match_start,
//                                               match_end, length_overflow)
// cfg      input      i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One input request per cycle; a byte request updates the window and the
// first-occurrence tracker in the cycle it is accepted, with no result.
// An end request loads its result into the output register, visible in the next cycle.
// The limit is the single output register: input is taken while it is empty
// or its result leaves in the same cycle.
// Synchronous active-low reset clears configuration, string state and the
// output valid flag; the input side is not ready during reset.
module anchored_literal_substring_match_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  alsm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output alsm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [alsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [alsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [alsm_pkg::CFG_DATA_W-1:0]  r_pat_low;
    logic [alsm_pkg::CFG_DATA_W-1:0]  r_pat_high;
    logic [alsm_pkg::CFG_LEN_W-1:0]   r_pat_len;
    logic                             r_anchor_start;
    logic                             r_anchor_end;
    logic                             r_live;
    logic                             r_out_valid;
    alsm_pkg::t_out_item              r_out;
    alsm_pkg::t_out_item              n_out;

    logic [alsm_pkg::LEN_W-1:0]       eff_len;
    logic [2*alsm_pkg::CFG_DATA_W-1:0] pat_bytes;
    alsm_pkg::t_pattern               pattern;
    alsm_pkg::t_trk_ctrl              trk_ctrl;
    alsm_pkg::t_trk_status            trk_status;
    logic                             in_fire;
    logic                             end_fire;
    logic                             hit;
    logic [alsm_pkg::OFFSET_W-1:0]    start;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low      <= '0;
            r_pat_high     <= '0;
            r_pat_len      <= '0;
            r_anchor_start <= 1'b0;
            r_anchor_end   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                alsm_pkg::CFG_PATTERN_LOW:  r_pat_low      <= i_cfg_data;
                alsm_pkg::CFG_PATTERN_HIGH: r_pat_high     <= i_cfg_data;
                alsm_pkg::CFG_PATTERN_LEN:  r_pat_len      <= i_cfg_data[alsm_pkg::CFG_LEN_W-1:0];
                alsm_pkg::CFG_ANCHOR_START: r_anchor_start <= i_cfg_data[0];
                alsm_pkg::CFG_ANCHOR_END:   r_anchor_end   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the length and drop pattern bytes beyond the window
    assign eff_len = (r_pat_len > alsm_pkg::CFG_LEN_W'(alsm_pkg::MAX_PATTERN))
                   ? alsm_pkg::LEN_W'(alsm_pkg::MAX_PATTERN)
                   : r_pat_len[alsm_pkg::LEN_W-1:0];
    assign pat_bytes = {r_pat_high, r_pat_low};
    assign pattern   = pat_bytes[alsm_pkg::MAX_PATTERN*8-1:0];

    // Accept input while the output register is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign o_in_ready     = r_live && (!r_out_valid || i_out_ready);
    assign in_fire        = i_in_valid && o_in_ready;
    assign end_fire       = in_fire && i_in_data.is_end;
    assign trk_ctrl.shift = in_fire && !i_in_data.is_end;
    assign trk_ctrl.clear = end_fire;

    alsm_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (trk_ctrl),
        .i_byte   (i_in_data.text_byte),
        .i_pattern(pattern),
        .i_len    (eff_len),
        .o_status (trk_status)
    );

    // Decide the match at the end request
    always_comb begin
        hit   = 1'b0;
        start = '0;
        priority if (eff_len == '0) begin
            hit = 1'b1;
        end else if (r_anchor_start) begin
            hit = trk_status.seen && (trk_status.offset == '0)
                && !(r_anchor_end && (trk_status.count != alsm_pkg::COUNT_W'(eff_len)));
        end else if (r_anchor_end) begin
            hit   = trk_status.tail_hit;
            start = alsm_pkg::OFFSET_W'(trk_status.count - alsm_pkg::COUNT_W'(eff_len));
        end else begin
            hit   = trk_status.seen;
            start = alsm_pkg::OFFSET_W'(trk_status.offset);
        end
        n_out.matched         = hit;
        n_out.match_start     = hit ? start : '0;
        n_out.match_end       = hit ? (start + alsm_pkg::OFFSET_W'(eff_len)) : '0;
        n_out.length_overflow = trk_status.saturated;
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (end_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A new result appears only after an accepted end request
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(end_fire))
        else $error("result raised without an end request");

    // Every accepted end request is loaded into the output register
    a_end_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_fire |=> r_out_valid)
        else $error("end request lost");

    // A miss reports zero offsets
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.matched) |->
            (r_out.match_start == '0) && (r_out.match_end == '0))
        else $error("miss reported with nonzero offsets");

endmodule

FILE: hdl/alsm_compare.sv
module alsm_compare (
    input  alsm_pkg::t_window                 i_window,
    input  alsm_pkg::t_pattern                i_pattern,
    input  logic [alsm_pkg::LEN_W-1:0]        i_len,
    input  logic [alsm_pkg::COUNT_W-1:0]      i_count,
    output logic                              o_hit
);

    logic [alsm_pkg::MAX_PATTERN-1:0] byte_ok;

    // Compare window byte j against pattern byte len-1-j, in parallel
    always_comb begin
        logic [alsm_pkg::LEN_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < alsm_pkg::MAX_PATTERN; j++) begin
            idx = i_len - alsm_pkg::LEN_W'(j + 1);
            if (alsm_pkg::LEN_W'(j) < i_len) begin
                byte_ok[j] = (i_window[j] == i_pattern[idx[alsm_pkg::PAT_IDX_W-1:0]]);
            end else begin
                byte_ok[j] = 1'b1;
            end
        end
    end

    // Hit only when enough bytes have arrived to fill the pattern
    assign o_hit = (i_count >= alsm_pkg::COUNT_W'(i_len)) && (&byte_ok);

endmodule

FILE: hdl/alsm_tracker.sv
module alsm_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  alsm_pkg::t_trk_ctrl            i_ctrl,
    input  logic [7:0]                     i_byte,
    input  alsm_pkg::t_pattern             i_pattern,
    input  logic [alsm_pkg::LEN_W-1:0]     i_len,
    output alsm_pkg::t_trk_status          o_status
);

    alsm_pkg::t_window               r_window;
    alsm_pkg::t_window               n_window;
    logic [alsm_pkg::COUNT_W-1:0]    r_count;
    logic [alsm_pkg::COUNT_W-1:0]    n_count;
    logic [alsm_pkg::COUNT_W-1:0]    r_offset;
    logic                            r_seen;
    logic                            r_sat;
    logic                            at_limit;
    logic                            next_hit;
    logic                            tail_hit;

    // Shift the new byte in at the newest end of the window
    always_comb begin
        n_window[0] = i_byte;
        for (int j = 1; j < alsm_pkg::WINDOW_DEPTH; j++) begin
            n_window[j] = r_window[j-1];
        end
    end

    // Advance the position counter, hold it at the limit
    assign at_limit = (r_count == alsm_pkg::COUNT_LIMIT);
    assign n_count  = at_limit ? r_count : r_count + alsm_pkg::COUNT_W'(1);

    // Compare with the byte just arriving, and with the window as it stands
    alsm_compare u_next_cmp (
        .i_window  (n_window),
        .i_pattern (i_pattern),
        .i_len     (i_len),
        .i_count   (n_count),
        .o_hit     (next_hit)
    );

    alsm_compare u_tail_cmp (
        .i_window  (r_window),
        .i_pattern (i_pattern),
        .i_len     (i_len),
        .i_count   (r_count),
        .o_hit     (tail_hit)
    );

    // Hold window bytes; only positions below the count are ever compared
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_window <= n_window;
        end
    end

    // Track count, saturation and the first occurrence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_count  <= '0;
            r_offset <= '0;
            r_seen   <= 1'b0;
            r_sat    <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_count <= n_count;
            r_sat   <= r_sat | at_limit;
            if (!r_seen && (i_len != '0) && next_hit) begin
                r_seen   <= 1'b1;
                r_offset <= n_count - alsm_pkg::COUNT_W'(i_len);
            end
        end
    end

    assign o_status = '{
        seen:      r_seen,
        offset:    r_offset,
        count:     r_count,
        saturated: r_sat,
        tail_hit:  tail_hit
    };

    // The first occurrence never lies past the current count
    a_offset_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_offset <= r_count))
        else $error("occurrence offset beyond byte count");

    // Saturation is flagged only with the counter at its limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_count == alsm_pkg::COUNT_LIMIT))
        else $error("saturation flag without counter at limit");

    // An end request returns the string state to its cleared values
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> (r_count == '0) && !r_seen && !r_sat)
        else $error("string state not cleared after end request");

endmodule

FILE: verif/alsm_match_checker.sv
`timescale 1ns / 1ps

module alsm_match_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  alsm_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  alsm_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [alsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count
);

    localparam int PRINT_LIMIT = 40;

    // Shadow copy of the pattern registers
    logic [63:0]                    pat_low;
    logic [63:0]                    pat_high;
    logic [alsm_pkg::CFG_LEN_W-1:0] pat_len;
    logic                           want_prefix;
    logic                           want_suffix;

    // Shadow copy of the per-string search state
    alsm_pkg::t_window              window_bytes;
    logic [alsm_pkg::COUNT_W-1:0]   byte_total;
    logic                           first_seen;
    logic [alsm_pkg::COUNT_W-1:0]   first_offset;
    logic                           total_saturated;

    alsm_pkg::t_out_item            expected_results[$];
    int                             pending_total = 0;
    int                             fail_total = 0;

    assign o_pending    = pending_total;
    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_total < PRINT_LIMIT) begin
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        fail_total++;
    endtask

    // Clamp the programmed length to the window size
    function automatic int unsigned active_length();
        if (pat_len > alsm_pkg::MAX_PATTERN) begin
            return alsm_pkg::MAX_PATTERN;
        end
        return pat_len;
    endfunction

    // True when the newest n bytes equal the first n pattern bytes
    function automatic logic tail_is_pattern(input int unsigned n);
        alsm_pkg::t_pattern p;
        p = {pat_high, pat_low};
        if (byte_total < n) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (window_bytes[n - 1 - i] != p[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_string();
        window_bytes    = '0;
        byte_total      = '0;
        first_seen      = 1'b0;
        first_offset    = '0;
        total_saturated = 1'b0;
    endtask

    // Shift a text byte in, advance the position and track the first occurrence
    task automatic absorb_byte(input logic [7:0] b);
        int unsigned n;
        n = active_length();
        window_bytes = {window_bytes[alsm_pkg::WINDOW_DEPTH-2:0], b};
        if (byte_total < alsm_pkg::COUNT_LIMIT) begin
            byte_total++;
        end else begin
            total_saturated = 1'b1;
        end
        if (!first_seen && n > 0 && tail_is_pattern(n)) begin
            first_seen   = 1'b1;
            first_offset = byte_total - n;
        end
    endtask

    // Decide the match at the terminator, then drop the string state
    task automatic close_string(output alsm_pkg::t_out_item r);
        int unsigned                   n;
        logic                          hit;
        logic [alsm_pkg::OFFSET_W-1:0] start;
        n     = active_length();
        start = '0;
        if (n == 0) begin
            hit = 1'b1;
        end else if (want_prefix) begin
            hit = first_seen && first_offset == 0;
            if (hit && want_suffix && byte_total != n) begin
                hit = 1'b0;
            end
        end else if (want_suffix) begin
            hit = tail_is_pattern(n);
            if (hit) begin
                start = byte_total - n;
            end
        end else begin
            hit   = first_seen;
            start = first_offset;
        end
        r.matched         = hit;
        r.match_start     = hit ? start : '0;
        r.match_end       = hit ? start + n : '0;
        r.length_overflow = total_saturated;
        clear_string();
    endtask

    task automatic check_result(input alsm_pkg::t_out_item got);
        alsm_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no pending request", 32'(got.matched), 32'd0);
        end else begin
            want = expected_results.pop_front();
            if (got.matched != want.matched) begin
                report_mismatch("matched", 32'(got.matched), 32'(want.matched));
            end
            if (got.match_start != want.match_start) begin
                report_mismatch("match_start", got.match_start, want.match_start);
            end
            if (got.match_end != want.match_end) begin
                report_mismatch("match_end", got.match_end, want.match_end);
            end
            if (got.length_overflow != want.length_overflow) begin
                report_mismatch("length_overflow", 32'(got.length_overflow),
                                32'(want.length_overflow));
            end
        end
    endtask

    // Watch all three ports on every edge
    always @(posedge i_clk) begin
        alsm_pkg::t_out_item predicted;
        if (!i_rst_n) begin
            pat_low     = '0;
            pat_high    = '0;
            pat_len     = '0;
            want_prefix = 1'b0;
            want_suffix = 1'b0;
            clear_string();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            // Compare with the registers as they stand before this edge
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.is_end) begin
                    close_string(predicted);
                    expected_results.push_back(predicted);
                end else begin
                    absorb_byte(i_in_data.text_byte);
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    alsm_pkg::CFG_PATTERN_LOW:  pat_low     = i_cfg_data;
                    alsm_pkg::CFG_PATTERN_HIGH: pat_high    = i_cfg_data;
                    alsm_pkg::CFG_PATTERN_LEN:  pat_len     = i_cfg_data[alsm_pkg::CFG_LEN_W-1:0];
                    alsm_pkg::CFG_ANCHOR_START: want_prefix = i_cfg_data[0];
                    alsm_pkg::CFG_ANCHOR_END:   want_suffix = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending_total = expected_results.size();
    end

endmodule

FILE: verif/anchored_literal_substring_match_core_tb.sv
`timescale 1ns / 1ps

module anchored_literal_substring_match_core_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int ITEM_TARGET   = 1125;
    localparam int CALM_ITEMS    = 120;
    localparam int HOLD_AT       = 400;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    alsm_pkg::t_in_item              i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    alsm_pkg::t_out_item             o_out_data;
    logic                            i_cfg_we    = 1'b0;
    logic [alsm_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [alsm_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    int                    expected_left;
    int                    mismatch_count;
    int                    sent_count = 0;
    bit                    calm = 1'b0;
    bit                    long_hold_req = 1'b0;
    bit                    sender_gaps = 1'b1;

    // Text generation for the current phase
    alsm_pkg::t_pattern    cur_pattern;
    int unsigned           pat_eff;
    logic [7:0]            alpha[4];
    int unsigned           alpha_size = 1;
    bit                    wide_text = 1'b0;
    logic [7:0]            text_buf[$];

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    anchored_literal_substring_match_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    alsm_match_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (expected_left),
        .o_fail_count (mismatch_count)
    );

    // Offer one request and hold it until accepted, then maybe idle
    task automatic send_request(input logic [7:0] b, input logic is_end);
        alsm_pkg::t_in_item req;
        req.text_byte = b;
        req.is_end    = is_end;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
        if (sent_count == HOLD_AT) begin
            long_hold_req = 1'b1;
        end
        if (sent_count >= ITEM_TARGET - CALM_ITEMS) begin
            calm = 1'b1;
        end
        if (!calm && sender_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [alsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Program all registers; spare upper bits carry noise
    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] n, input logic a_s, input logic a_e);
        logic [63:0] word;
        write_reg(alsm_pkg::CFG_PATTERN_LOW, lo);
        write_reg(alsm_pkg::CFG_PATTERN_HIGH, hi);
        word = {$urandom, $urandom};
        word[alsm_pkg::CFG_LEN_W-1:0] = n;
        write_reg(alsm_pkg::CFG_PATTERN_LEN, word);
        word = {$urandom, $urandom};
        word[0] = a_s;
        write_reg(alsm_pkg::CFG_ANCHOR_START, word);
        word = {$urandom, $urandom};
        word[0] = a_e;
        write_reg(alsm_pkg::CFG_ANCHOR_END, word);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has drained
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_left != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        if (wide_text) begin
            return 8'($urandom);
        end
        return alpha[$urandom_range(0, alpha_size - 1)];
    endfunction

    task automatic append_noise(input int unsigned n);
        repeat (n) text_buf.push_back(pick_text_byte());
    endtask

    task automatic append_pattern(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            text_buf.push_back(cur_pattern[i]);
        end
    endtask

    task automatic send_text(input bit with_end);
        foreach (text_buf[i]) begin
            send_request(text_buf[i], 1'b0);
        end
        if (with_end) begin
            send_request(8'($urandom), 1'b1);
        end
    endtask

    // Mostly strings that carry the pattern somewhere, some noise and broken copies
    task automatic build_text();
        int unsigned kind;
        int unsigned pre;
        int unsigned suf;
        text_buf.delete();
        kind = $urandom_range(0, 9);
        pre  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
        suf  = $urandom_range(1, 6);
        case (kind)
            0, 1: append_noise($urandom_range(0, 20));
            2, 3: append_pattern(pat_eff);
            4, 5: begin
                append_pattern(pat_eff);
                append_noise(suf);
            end
            6, 7: begin
                append_noise(pre);
                append_pattern(pat_eff);
            end
            8: begin
                append_noise(pre);
                append_pattern(pat_eff);
                append_noise(suf);
                append_pattern(pat_eff);
            end
            default: begin
                append_noise(pre);
                append_pattern((pat_eff > 0) ? $urandom_range(0, pat_eff - 1) : 0);
            end
        endcase
    endtask

    task automatic run_random_phase();
        int unsigned mode;
        int unsigned len_pick;
        logic [4:0]  plen;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            wide_text  = 1'b0;
            alpha_size = 2;
            alpha[0]   = 8'h00;
            alpha[1]   = 8'hFF;
        end else if (mode == 1) begin
            wide_text = 1'b1;
        end else begin
            wide_text  = 1'b0;
            alpha_size = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++) begin
                alpha[k] = 8'($urandom);
            end
        end
        len_pick = $urandom_range(0, 19);
        if (len_pick == 0) begin
            plen = 5'd0;
        end else if (len_pick == 1) begin
            plen = 5'd16;
        end else if (len_pick == 2) begin
            plen = 5'd31;
        end else if (len_pick == 3) begin
            plen = 5'($urandom_range(17, 30));
        end else if (len_pick < 12) begin
            plen = 5'($urandom_range(1, 4));
        end else begin
            plen = 5'($urandom_range(1, 16));
        end
        pat_eff = (plen > alsm_pkg::MAX_PATTERN) ? alsm_pkg::MAX_PATTERN : plen;
        for (int i = 0; i < alsm_pkg::MAX_PATTERN; i++) begin
            cur_pattern[i] = (i < pat_eff) ? pick_text_byte() : 8'($urandom);
        end
        load_config(cur_pattern[7:0], cur_pattern[15:8], plen,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sender_gaps = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(2, 10)) begin
            build_text();
            send_text(1'b1);
        end
        // Leave a string open so the next setting lands in mid-string
        if ($urandom_range(0, 3) == 0) begin
            text_buf.delete();
            append_pattern($urandom_range(0, pat_eff));
            append_noise($urandom_range(0, 3));
            send_text(1'b0);
        end
        settle();
    endtask

    // Receiver: short stalls, calm stretches, and one long hold-off
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else if ($urandom_range(0, 15) == 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern after reset: empty string matches at 0..0
        send_request(8'hFF, 1'b1);
        settle();

        // Unanchored "ab" inside "xab"
        load_config(64'h6261, 64'h0, 5'd2, 1'b0, 1'b0);
        send_request(8'h78, 1'b0);
        send_request(8'h61, 1'b0);
        send_request(8'h62, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        // Both anchors: string equals the pattern
        load_config(64'h6261, 64'h0, 5'd2, 1'b1, 1'b1);
        send_request(8'h61, 1'b0);
        send_request(8'h62, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        // Oversized length clamps to a full window of alternating 00/FF bytes
        cur_pattern = {64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00};
        load_config(cur_pattern[7:0], cur_pattern[15:8], 5'd31, 1'b0, 1'b0);
        for (int i = 0; i < alsm_pkg::MAX_PATTERN; i++) begin
            send_request(cur_pattern[i], 1'b0);
        end
        send_request(8'h00, 1'b1);
        settle();

        while (sent_count < ITEM_TARGET) begin
            run_random_phase();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule
